@@ sv/point_on_segment_at_distance_defines.svh @@
// assertion macros for the segment point block
`ifndef POINT_ON_SEGMENT_AT_DISTANCE_DEFINES_SVH
`define POINT_ON_SEGMENT_AT_DISTANCE_DEFINES_SVH
// implication checked every clock outside reset
`define POS_ASSERT_IMP(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
// next-cycle implication checked outside reset
`define POS_ASSERT_NXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`endif

@@ sv/posd_pkg.sv @@
// shared constants, types and helpers for the segment point block
`timescale 1ns / 1ps
package posd_pkg;
  localparam int CoordWidth = 16;
  localparam int DiffWidth  = CoordWidth + 1;
  localparam int MagWidth   = CoordWidth;
  localparam int SqWidth    = 2 * MagWidth + 1;
  localparam int RootWidth  = (SqWidth + 1) / 2;
  localparam int SqrtSteps  = RootWidth;
  localparam int ProdWidth  = DiffWidth + CoordWidth;
  localparam int QuotWidth  = ProdWidth;
  localparam int DivSteps   = QuotWidth;
  localparam int OutWidth   = 32;
  localparam int SumWidth   = QuotWidth + 1;

  typedef logic signed [CoordWidth-1:0] coord_t;
  typedef logic signed [OutWidth-1:0]   outw_t;

  // data carried by every cell of the pipeline
  typedef struct packed {
    logic                  vld;
    coord_t                sx;
    coord_t                sy;
    logic [SqWidth-1:0]    rem_sq;
    logic [RootWidth-1:0]  root;
    logic [ProdWidth-1:0]  num_x;
    logic [ProdWidth-1:0]  num_y;
    logic                  neg_x;
    logic                  neg_y;
    logic [ProdWidth:0]    rem_x;
    logic [ProdWidth:0]    rem_y;
    logic [QuotWidth-1:0]  quo_x;
    logic [QuotWidth-1:0]  quo_y;
  } posd_cell_t;

  function automatic outw_t sat_out(input logic signed [SumWidth-1:0] v);
    logic signed [SumWidth-1:0] hi;
    logic signed [SumWidth-1:0] lo;
    hi = SumWidth'(signed'({1'b0, {(OutWidth-1){1'b1}}}));
    lo = -hi - SumWidth'(1);
    if (v > hi) return outw_t'(hi);
    if (v < lo) return outw_t'(lo);
    return outw_t'(v);
  endfunction
endpackage

@@ sv/posd_if.sv @@
// valid/ready channel interfaces for the segment point block
`timescale 1ns / 1ps
interface posd_in_if import posd_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t start_x;
  coord_t start_y;
  coord_t end_x;
  coord_t end_y;
  coord_t travel;
  modport source (output valid, start_x, start_y, end_x, end_y, travel, input ready);
  modport sink (input valid, start_x, start_y, end_x, end_y, travel, output ready);
endinterface

interface posd_out_if import posd_pkg::*; ();
  logic  valid;
  logic  ready;
  outw_t point_x;
  outw_t point_y;
  modport source (output valid, point_x, point_y, input ready);
  modport sink (input valid, point_x, point_y, output ready);
endinterface

@@ sv/point_on_segment_at_distance.sv @@
// top level: entry stage, square-root cell row, product stage, divider cell row, output stage
// throughput: one transaction per cycle; a chain of one-bit cells for the square root
// and for both divisions carries every transaction, all cells advance together
// when the output register is free or being taken
// reset: synchronous active-low rst_n clears all valid bits; no clearing pass
`timescale 1ns / 1ps
module point_on_segment_at_distance import posd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  posd_in_if.sink    in_ch,
  posd_out_if.source out_ch
);
  posd_cell_t chain [SqrtSteps+1];
  posd_cell_t entry_r;
  posd_cell_t entry_nxt;
  posd_cell_t prod_r;
  posd_cell_t prod_nxt;
  coord_t     travel_r;
  coord_t     trav_p_r [SqrtSteps+1];
  logic signed [DiffWidth-1:0] dx_r, dy_r;
  logic signed [DiffWidth-1:0] dxp_r [SqrtSteps+1];
  logic signed [DiffWidth-1:0] dyp_r [SqrtSteps+1];
  logic        en;
  logic        out_vld_r;
  outw_t       px_r, py_r;

  // advance whenever the output register can take a new transaction
  assign en = !out_vld_r || out_ch.ready;
  assign in_ch.ready = en;

  // entry stage: differences and squared length
  logic signed [DiffWidth-1:0] dx_c, dy_c;
  logic [MagWidth-1:0] ax_c, ay_c;
  always_comb begin
    dx_c = DiffWidth'(in_ch.end_x) - DiffWidth'(in_ch.start_x);
    dy_c = DiffWidth'(in_ch.end_y) - DiffWidth'(in_ch.start_y);
    ax_c = MagWidth'(dx_c[DiffWidth-1] ? -dx_c : dx_c);
    ay_c = MagWidth'(dy_c[DiffWidth-1] ? -dy_c : dy_c);
    entry_nxt        = '0;
    entry_nxt.vld    = in_ch.valid;
    entry_nxt.sx     = in_ch.start_x;
    entry_nxt.sy     = in_ch.start_y;
    entry_nxt.rem_sq = SqWidth'(ax_c) * SqWidth'(ax_c) + SqWidth'(ay_c) * SqWidth'(ay_c);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r.vld <= 1'b0;
    end else if (en) begin
      entry_r  <= entry_nxt;
      dx_r     <= dx_c;
      dy_r     <= dy_c;
      travel_r <= in_ch.travel;
    end
  end

  assign chain[0] = entry_r;
  assign dxp_r[0] = dx_r;
  assign dyp_r[0] = dy_r;
  assign trav_p_r[0] = travel_r;

  for (genvar i = 0; i < SqrtSteps; i++) begin : g_sqrt
    posd_sqrt_cell u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .digit(5'(SqrtSteps - 1 - i)),
      .cell_in(chain[i]), .cell_out(chain[i+1])
    );
    // side operands travel alongside the root cells
    always_ff @(posedge clk) begin
      if (en) begin
        dxp_r[i+1]    <= dxp_r[i];
        dyp_r[i+1]    <= dyp_r[i];
        trav_p_r[i+1] <= trav_p_r[i];
      end
    end
  end

  // product stage: signed products split into sign and magnitude
  logic signed [ProdWidth-1:0] mx_c, my_c;
  always_comb begin
    mx_c = ProdWidth'(dxp_r[SqrtSteps]) * ProdWidth'(trav_p_r[SqrtSteps]);
    my_c = ProdWidth'(dyp_r[SqrtSteps]) * ProdWidth'(trav_p_r[SqrtSteps]);
    prod_nxt       = chain[SqrtSteps];
    prod_nxt.neg_x = mx_c[ProdWidth-1];
    prod_nxt.neg_y = my_c[ProdWidth-1];
    prod_nxt.num_x = mx_c[ProdWidth-1] ? -mx_c : mx_c;
    prod_nxt.num_y = my_c[ProdWidth-1] ? -my_c : my_c;
    prod_nxt.rem_x = '0;
    prod_nxt.rem_y = '0;
    prod_nxt.quo_x = '0;
    prod_nxt.quo_y = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_r.vld <= 1'b0;
    end else if (en) begin
      prod_r <= prod_nxt;
    end
  end

  posd_cell_t dchain [DivSteps+1];
  assign dchain[0] = prod_r;
  for (genvar j = 0; j < DivSteps; j++) begin : g_div
    posd_div_cell u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .cell_in(dchain[j]), .cell_out(dchain[j+1])
    );
  end

  // output stage: sign, add start point, saturate
  posd_cell_t fin;
  logic signed [SumWidth-1:0] qx_c, qy_c, rx_c, ry_c;
  always_comb begin
    fin  = dchain[DivSteps];
    qx_c = SumWidth'(fin.quo_x);
    qy_c = SumWidth'(fin.quo_y);
    if (fin.neg_x) qx_c = -qx_c;
    if (fin.neg_y) qy_c = -qy_c;
    if (fin.root == '0) begin
      rx_c = SumWidth'(fin.sx);
      ry_c = SumWidth'(fin.sy);
    end else begin
      rx_c = qx_c + SumWidth'(fin.sx);
      ry_c = qy_c + SumWidth'(fin.sy);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= fin.vld;
      px_r      <= sat_out(rx_c);
      py_r      <= sat_out(ry_c);
    end
  end

  assign out_ch.valid   = out_vld_r;
  assign out_ch.point_x = px_r;
  assign out_ch.point_y = py_r;
endmodule

@@ sv/posd_sqrt_cell.sv @@
// one digit of the restoring square root per cell
`timescale 1ns / 1ps
module posd_sqrt_cell import posd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       en,
  input  logic [4:0] digit,
  input  posd_cell_t cell_in,
  output posd_cell_t cell_out
);
  posd_cell_t cell_r;
  posd_cell_t cell_nxt;
  logic [SqWidth-1:0] trial;
  logic [SqWidth-1:0] bitv;

  always_comb begin
    cell_nxt = cell_in;
    // root holds the digits found so far; trial is (2*root + 2^digit) * 2^digit
    bitv  = SqWidth'(1) << {digit, 1'b0};
    trial = (SqWidth'(cell_in.root) << (digit + 5'd1)) + bitv;
    if (cell_in.rem_sq >= trial) begin
      cell_nxt.rem_sq = cell_in.rem_sq - trial;
      cell_nxt.root   = cell_in.root | (RootWidth'(1) << digit);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.vld <= 1'b0;
    end else if (en) begin
      cell_r <= cell_nxt;
    end
  end

  assign cell_out = cell_r;
endmodule

@@ sv/posd_div_cell.sv @@
// one quotient bit of both restoring divisions per cell
`timescale 1ns / 1ps
module posd_div_cell import posd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       en,
  input  posd_cell_t cell_in,
  output posd_cell_t cell_out
);
  posd_cell_t cell_r;
  posd_cell_t cell_nxt;
  logic [ProdWidth:0] sh_x;
  logic [ProdWidth:0] sh_y;
  logic [ProdWidth:0] dv;

  always_comb begin
    cell_nxt = cell_in;
    dv   = (ProdWidth+1)'(cell_in.root);
    sh_x = {cell_in.rem_x[ProdWidth-1:0], cell_in.num_x[ProdWidth-1]};
    sh_y = {cell_in.rem_y[ProdWidth-1:0], cell_in.num_y[ProdWidth-1]};
    cell_nxt.num_x = cell_in.num_x << 1;
    cell_nxt.num_y = cell_in.num_y << 1;
    if (sh_x >= dv) begin
      cell_nxt.rem_x = sh_x - dv;
      cell_nxt.quo_x = {cell_in.quo_x[QuotWidth-2:0], 1'b1};
    end else begin
      cell_nxt.rem_x = sh_x;
      cell_nxt.quo_x = {cell_in.quo_x[QuotWidth-2:0], 1'b0};
    end
    if (sh_y >= dv) begin
      cell_nxt.rem_y = sh_y - dv;
      cell_nxt.quo_y = {cell_in.quo_y[QuotWidth-2:0], 1'b1};
    end else begin
      cell_nxt.rem_y = sh_y;
      cell_nxt.quo_y = {cell_in.quo_y[QuotWidth-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.vld <= 1'b0;
    end else if (en) begin
      cell_r <= cell_nxt;
    end
  end

  assign cell_out = cell_r;
endmodule

@@ sv/posd_checker.sv @@
// port-level checker for the segment point block
`timescale 1ns / 1ps
`include "point_on_segment_at_distance_defines.svh"
module posd_checker import posd_pkg::*; (
  input logic  clk,
  input logic  rst_n,
  input logic  in_valid,
  input logic  in_ready,
  input logic  out_valid,
  input logic  out_ready,
  input outw_t point_x,
  input outw_t point_y
);
  `POS_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  `POS_ASSERT_NXT(a_data_hold, clk, rst_n, out_valid && !out_ready, $stable(point_x) && $stable(point_y))
  `POS_ASSERT_IMP(a_ready_free, clk, rst_n, !out_valid, in_ready)
  `POS_ASSERT_IMP(a_ready_stall, clk, rst_n, out_valid && !out_ready, !in_ready)
endmodule

bind point_on_segment_at_distance posd_checker u_posd_checker (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .point_x(out_ch.point_x), .point_y(out_ch.point_y)
);

@@ tb/tb.sv @@
// testbench for the segment point block: scoreboard class, random traffic, stalls
`timescale 1ns / 1ps
module tb;
  import posd_pkg::*;

  typedef struct {
    coord_t sx;
    coord_t sy;
    coord_t ex;
    coord_t ey;
    coord_t tr;
  } seg_query_t;

  typedef struct {
    outw_t px;
    outw_t py;
  } seg_point_t;

  class point_scoreboard;
    seg_point_t pending[$];
    int unsigned n_fail;
    int unsigned n_checked;

    function automatic longint root_floor(longint unsigned n);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
        if (n >= r + b) begin
          n = n - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return longint'(r);
    endfunction

    function automatic outw_t clamp32(longint v);
      if (v > 64'sd2147483647) return 32'h7fffffff;
      if (v < -64'sd2147483648) return 32'h80000000;
      return outw_t'(v);
    endfunction

    // note an accepted transaction and compute where its point lands
    function void note_query(seg_query_t q);
      longint dx;
      longint dy;
      longint len;
      longint px;
      longint py;
      seg_point_t p;
      dx = longint'(q.ex) - longint'(q.sx);
      dy = longint'(q.ey) - longint'(q.sy);
      len = root_floor(longint'(dx * dx + dy * dy));
      px = q.sx;
      py = q.sy;
      if (len > 0) begin
        // sv division on signed longint truncates toward zero
        px = (dx * longint'(q.tr)) / len + q.sx;
        py = (dy * longint'(q.tr)) / len + q.sy;
      end
      p.px = clamp32(px);
      p.py = clamp32(py);
      pending.push_back(p);
    endfunction

    function void check_point(outw_t ax, outw_t ay);
      seg_point_t e;
      n_checked++;
      if (pending.size() == 0) begin
        $error("unexpected result x=%0d y=%0d", ax, ay);
        n_fail++;
        return;
      end
      e = pending.pop_front();
      if (ax !== e.px) begin
        $error("point_x expected %0d actual %0d", e.px, ax);
        n_fail++;
      end
      if (ay !== e.py) begin
        $error("point_y expected %0d actual %0d", e.py, ay);
        n_fail++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  posd_in_if in_ch ();
  posd_out_if out_ch ();
  point_scoreboard sb;
  seg_query_t queries[$];
  int unsigned idle_cycles;
  int unsigned n_sent;
  int unsigned n_degenerate;

  point_on_segment_at_distance dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic coord_t rand_coord(int mode);
    case (mode)
      0: return coord_t'($urandom);
      1: return coord_t'($urandom_range(0, 40)) - coord_t'(20);
      2: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      default: return coord_t'($urandom_range(0, 2000)) - coord_t'(1000);
    endcase
  endfunction

  task automatic add_query(coord_t sx, coord_t sy, coord_t ex, coord_t ey, coord_t tr);
    seg_query_t q;
    q.sx = sx; q.sy = sy; q.ex = ex; q.ey = ey; q.tr = tr;
    queries.push_back(q);
  endtask

  task automatic build_queries();
    seg_query_t q;
    add_query(16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0100);
    add_query(16'sh1234, -16'sh0042, 16'sh1234, -16'sh0042, 16'sh7fff);
    add_query(16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff);
    add_query(16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000);
    add_query(16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff);
    add_query(16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh8000);
    add_query(16'sh0000, 16'sh0000, 16'sh0001, 16'sh0000, 16'sh7fff);
    add_query(16'sh7fff, 16'sh7fff, 16'sh7ffe, 16'sh7fff, 16'sh8000);
    add_query(16'sh8000, 16'sh8000, 16'sh8001, 16'sh8001, 16'sh8000);
    add_query(16'sh0000, 16'sh0000, 16'sh0003, 16'sh0004, 16'sh000a);
    add_query(16'sh0000, 16'sh0000, 16'sh0003, 16'sh0004, -16'sh000a);
    add_query(16'sh0000, 16'sh0000, -16'sh0003, 16'sh0004, 16'sh0007);
    add_query(16'sh0000, 16'sh0000, 16'sh0003, -16'sh0007, -16'sh0005);
    add_query(16'sh0010, 16'sh0010, 16'sh0011, 16'sh0011, 16'sh0000);
    add_query(16'shffff, 16'shffff, 16'sh0000, 16'sh0000, 16'shffff);
    add_query(16'sh5555, 16'shaaaa, 16'shaaaa, 16'sh5555, 16'sh5555);
    add_query(16'shaaaa, 16'sh5555, 16'sh5555, 16'shaaaa, 16'shaaaa);
    add_query(16'sh0000, 16'sh0000, 16'sh0000, 16'sh8000, 16'sh8000);
    add_query(16'sh7fff, 16'sh0000, 16'sh8000, 16'sh0000, 16'sh7fff);
    for (int i = 0; i < 1150; i++) begin
      q.sx = rand_coord($urandom_range(0, 3));
      q.sy = rand_coord($urandom_range(0, 3));
      if ($urandom_range(0, 19) == 0) begin
        q.ex = q.sx;
        q.ey = q.sy;
      end else if ($urandom_range(0, 5) == 0) begin
        // short segments, where the truncating divide matters most
        q.ex = q.sx + coord_t'($urandom_range(0, 6)) - coord_t'(3);
        q.ey = q.sy + coord_t'($urandom_range(0, 6)) - coord_t'(3);
      end else begin
        q.ex = rand_coord($urandom_range(0, 3));
        q.ey = rand_coord($urandom_range(0, 3));
      end
      q.tr = rand_coord($urandom_range(0, 3));
      queries.push_back(q);
    end
  endtask

  // sender: bursts with gaps, and one pause until the pipeline drains
  task automatic send_all();
    int burst;
    int idx;
    bit drained;
    idx = 0;
    drained = 1'b0;
    while (idx < queries.size()) begin
      burst = $urandom_range(1, 40);
      while (burst > 0 && idx < queries.size()) begin
        in_ch.valid <= 1'b1;
        in_ch.start_x <= queries[idx].sx;
        in_ch.start_y <= queries[idx].sy;
        in_ch.end_x <= queries[idx].ex;
        in_ch.end_y <= queries[idx].ey;
        in_ch.travel <= queries[idx].tr;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        idx++;
        burst--;
      end
      if (!drained && idx >= 400) begin
        drained = 1'b1;
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0) @(posedge clk);
      end else if ($urandom_range(0, 2) != 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
    in_ch.valid <= 1'b0;
  endtask

  // receiver stall pattern: stretches of full rate, then random ready
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (($urandom_range(0, 255) < 96) || ((n_sent / 200) % 2 == 0)) begin
      out_ch.ready <= 1'b1;
    end else begin
      out_ch.ready <= ($urandom_range(0, 3) != 0);
    end
  end

  // monitor and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        sb.note_query('{in_ch.start_x, in_ch.start_y, in_ch.end_x, in_ch.end_y, in_ch.travel});
        n_sent++;
        if (in_ch.start_x == in_ch.end_x && in_ch.start_y == in_ch.end_y) n_degenerate++;
      end
      if (out_ch.valid && out_ch.ready) sb.check_point(out_ch.point_x, out_ch.point_y);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles > 5000) begin
        $display("watchdog expired with %0d results outstanding", sb.pending.size());
        $display("tb failed");
        $finish;
      end
    end
  end

  initial begin
    sb = new();
    rst_n = 1'b0;
    idle_cycles = 0;
    n_sent = 0;
    n_degenerate = 0;
    in_ch.valid = 1'b0;
    in_ch.start_x = '0;
    in_ch.start_y = '0;
    in_ch.end_x = '0;
    in_ch.end_y = '0;
    in_ch.travel = '0;
    build_queries();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_all();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    $display("sent %0d segment queries (%0d degenerate), checked %0d points",
             n_sent, n_degenerate, sb.n_checked);
    $display("covered field extremes, beyond-segment travel and signed truncation");
    if (sb.n_fail == 0 && sb.pending.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end
endmodule
